### hw/rtl/brs_pkg.sv
// shared types, codes and bit-counting helpers for the rank/select bit vector
package brs_pkg;

    localparam int POS_W     = 13;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int CNT_W     = 7;
    localparam int MAX_WORDS = 2 ** (POS_W - BIT_W);

    localparam logic [POS_W-1:0] UNIVERSE_RESET = 13'd4096;

    localparam logic [2:0] OP_SET_RUN     = 3'd0;
    localparam logic [2:0] OP_RANK        = 3'd1;
    localparam logic [2:0] OP_SELECT      = 3'd2;
    localparam logic [2:0] OP_SELECT_NEXT = 3'd3;
    localparam logic [2:0] OP_IS_SET      = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] answer;
        logic             bit_set;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] ones;
        logic             any;
        logic [BIT_W-1:0] first_idx;
        logic [BIT_W-1:0] last_idx;
    } t_word_info;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, b[k]};
        end
        return cnt;
    endfunction

    // index of the target-th set bit of a byte, target counted from 1
    function automatic logic [2:0] byte_select(input logic [7:0] b, input logic [3:0] target);
        logic [3:0] seen;
        logic [2:0] idx;
        logic       hit;
        seen = '0;
        idx  = '0;
        hit  = 1'b0;
        for (int k = 0; k < 8; k++) begin
            seen = seen + {3'b000, b[k]};
            if (!hit && b[k] && (seen == target)) begin
                idx = 3'(k);
                hit = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

### hw/rtl/bitvector_rank_select.sv
// Rank/select bit vector. The bits live in a ram of 64-bit words; an
// operation streams the words it covers through the single read port, one
// word per cycle, with a popcount and bit search on each word as it returns.
// set_run, rank, select and select_next stream the words between the
// operation's first and last bit position (up to 64 words at the default
// size); select then finds the bit inside the word that holds it, one byte
// a cycle. is_set reads a single word. set_run writes each word back in
// the cycle its data returns while the next word is read. Per-word valid
// flags make the store read as all zeros right after reset, so no clearing
// pass is needed. One operation is in flight at a time; the next one is
// taken while the last result waits in the output register.
module bitvector_rank_select #(
    parameter int MAX_BITS = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [brs_pkg::POS_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  brs_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output brs_pkg::t_out_item        o_out_data
);
    import brs_pkg::*;

    localparam int WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int DEPTH = (WORDS > MAX_WORDS) ? MAX_WORDS : WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_BITS >= 2 ** POS_W) ? POS_W : $clog2(MAX_BITS);
    localparam int CAP   = (MAX_BITS > 2 ** POS_W - 1) ? 2 ** POS_W - 1 : MAX_BITS;
    localparam logic [POS_W-1:0] SIZE_CAP = POS_W'(CAP);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_REFINE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // control state
    logic [1:0]       r_state, n_state;
    logic [POS_W-1:0] r_universe;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic             r_rd_on, n_rd_on;
    logic             r_pend, n_pend;
    logic [DEPTH-1:0] r_valid;
    logic             r_out_valid;

    // operation payload
    logic [2:0]        r_op, n_op;
    logic [POS_W-1:0]  r_amount, n_amount;
    logic [POS_W-1:0]  r_lo, n_lo;
    logic [POS_W-1:0]  r_hi_m1, n_hi_m1;
    logic [POS_W-1:0]  r_count, n_count;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [AW-1:0]     r_pend_addr;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [2:0]        r_byte, n_byte;
    logic [WORD_W-1:0] r_word, n_word;
    logic [AW-1:0]     r_word_addr, n_word_addr;
    t_out_item         r_res, n_res;
    t_out_item         r_out;

    // accept-time decode
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] a_pos;
    logic [POS_W-1:0] a_amt;
    logic [POS_W:0]   a_run_end;
    logic [POS_W-1:0] a_lo;
    logic [POS_W-1:0] a_hi;
    logic             a_empty;
    logic             accept;

    // word pipeline
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] w_sel;
    logic [WORD_W-1:0] w_merged;
    t_word_info        w_info;
    logic              w_last;
    logic [AW-1:0]     lo_word;
    logic [AW-1:0]     hi_word;
    logic [POS_W:0]    sel_sum;
    logic [POS_W-1:0]  sel_rem;
    logic              ram_we;

    // refine step
    logic [7:0] ref_byte;
    logic [3:0] ref_ones;
    logic [2:0] ref_bit;

    logic out_free;

    assign size       = (r_universe > SIZE_CAP) ? SIZE_CAP : r_universe;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign a_pos     = i_in_data.position;
    assign a_amt     = i_in_data.amount;
    assign a_run_end = {1'b0, a_pos} + {1'b0, a_amt};

    // each op covers the bit positions [lo, hi)
    always_comb begin
        case (i_in_data.op)
            OP_SET_RUN: begin
                a_lo = a_pos;
                a_hi = (a_run_end > {1'b0, size}) ? size : a_run_end[POS_W-1:0];
            end
            OP_RANK: begin
                a_lo = '0;
                a_hi = (a_pos < size) ? a_pos : size;
            end
            OP_SELECT: begin
                a_lo = '0;
                if (a_amt == '0) begin
                    a_hi = (size != '0) ? POS_W'(1) : '0;
                end else begin
                    a_hi = size;
                end
            end
            OP_SELECT_NEXT: begin
                a_lo = POS_W'(r_cursor) + POS_W'(1);
                a_hi = size;
            end
            OP_IS_SET: begin
                a_lo = a_pos;
                a_hi = (a_pos < size) ? a_pos + POS_W'(1) : a_pos;
            end
            default: begin
                a_lo = '0;
                a_hi = '0;
            end
        endcase
    end

    assign a_empty = (a_lo >= a_hi);

    assign lo_word = r_lo[BIT_W +: AW];
    assign hi_word = r_hi_m1[BIT_W +: AW];
    assign w_last  = (r_pend_addr == hi_word);

    brs_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pend_addr),
        .i_wdata (w_merged),
        .i_re    (r_rd_on),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    brs_word_eval u_eval (
        .i_data       (rd_data),
        .i_word_valid (r_valid[r_pend_addr]),
        .i_lo_here    (r_pend_addr == lo_word),
        .i_lo_bit     (r_lo[BIT_W-1:0]),
        .i_hi_here    (w_last),
        .i_hi_bit     (r_hi_m1[BIT_W-1:0]),
        .o_sel        (w_sel),
        .o_merged     (w_merged),
        .o_info       (w_info)
    );

    assign sel_sum  = {1'b0, r_count} + (POS_W + 1)'(w_info.ones);
    assign sel_rem  = r_amount - r_count;
    assign ref_byte = r_word[{r_byte, 3'b000} +: 8];
    assign ref_ones = popcount8(ref_byte);
    assign ref_bit  = byte_select(ref_byte, r_rem[3:0]);

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_rd_on     = r_rd_on;
        n_pend      = r_rd_on;
        n_rd_addr   = r_rd_addr;
        n_op        = r_op;
        n_amount    = r_amount;
        n_lo        = r_lo;
        n_hi_m1     = r_hi_m1;
        n_count     = r_count;
        n_rem       = r_rem;
        n_byte      = r_byte;
        n_word      = r_word;
        n_word_addr = r_word_addr;
        n_res       = r_res;
        ram_we      = 1'b0;

        // read issue runs ahead of the word being processed
        if (r_rd_on) begin
            if (r_rd_addr == hi_word) begin
                n_rd_on = 1'b0;
            end else begin
                n_rd_addr = r_rd_addr + AW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_in_data.op;
                    n_amount  = a_amt;
                    n_lo      = a_lo;
                    n_hi_m1   = a_hi - POS_W'(1);
                    n_count   = '0;
                    n_rd_addr = a_lo[BIT_W +: AW];
                    n_res     = '0;
                    if (i_in_data.op > OP_IS_SET) begin
                        n_state = S_IDLE;
                    end else if (a_empty) begin
                        // nothing to scan: answer straight away, or for set_run go back to idle
                        if (i_in_data.op == OP_SELECT || i_in_data.op == OP_SELECT_NEXT) begin
                            n_res.answer = size;
                        end
                        n_state = (i_in_data.op == OP_SET_RUN) ? S_IDLE : S_DONE;
                    end else begin
                        n_rd_on = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    case (r_op)
                        OP_SET_RUN: begin
                            ram_we = 1'b1;
                            if (w_last) begin
                                n_state = S_IDLE;
                            end
                        end
                        OP_RANK: begin
                            n_count = sel_sum[POS_W-1:0];
                            if (w_info.any) begin
                                n_cursor = CW'({r_pend_addr, w_info.last_idx});
                            end
                            if (w_last) begin
                                n_res.answer = sel_sum[POS_W-1:0];
                                n_state      = S_DONE;
                            end
                        end
                        OP_SELECT: begin
                            if (r_amount == '0) begin
                                // target zero only matches a clear bit 0
                                if (w_info.any) begin
                                    n_res.answer = size;
                                end else begin
                                    n_res.answer = '0;
                                    n_cursor     = '0;
                                end
                                n_state = S_DONE;
                            end else if (sel_sum >= {1'b0, r_amount}) begin
                                n_rem       = sel_rem[CNT_W-1:0];
                                n_word      = w_sel;
                                n_word_addr = r_pend_addr;
                                n_byte      = '0;
                                n_state     = S_REFINE;
                            end else if (w_last) begin
                                n_res.answer = size;
                                n_state      = S_DONE;
                            end else begin
                                n_count = sel_sum[POS_W-1:0];
                            end
                        end
                        OP_SELECT_NEXT: begin
                            if (w_info.any) begin
                                n_res.answer = POS_W'({r_pend_addr, w_info.first_idx});
                                n_cursor     = CW'({r_pend_addr, w_info.first_idx});
                                n_state      = S_DONE;
                            end else if (w_last) begin
                                n_res.answer = size;
                                n_state      = S_DONE;
                            end
                        end
                        OP_IS_SET: begin
                            n_res.bit_set = w_info.any;
                            n_state       = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
                // stop the stream on any early exit
                if (n_state != S_SCAN) begin
                    n_rd_on = 1'b0;
                    n_pend  = 1'b0;
                end
            end
            S_REFINE: begin
                if (r_rem <= CNT_W'(ref_ones)) begin
                    n_res.answer = POS_W'({r_word_addr, r_byte, ref_bit});
                    n_cursor     = CW'({r_word_addr, r_byte, ref_bit});
                    n_state      = S_DONE;
                end else begin
                    n_rem  = r_rem - CNT_W'(ref_ones);
                    n_byte = r_byte + 3'd1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_universe  <= UNIVERSE_RESET;
            r_cursor    <= '0;
            r_rd_on     <= 1'b0;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_rd_on  <= n_rd_on;
            r_pend   <= n_pend;
            if (i_cfg_we) begin
                r_universe <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_valid[r_pend_addr] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_amount    <= n_amount;
        r_lo        <= n_lo;
        r_hi_m1     <= n_hi_m1;
        r_count     <= n_count;
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= r_rd_addr;
        r_rem       <= n_rem;
        r_byte      <= n_byte;
        r_word      <= n_word;
        r_word_addr <= n_word_addr;
        r_res       <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend || r_rd_on) |-> (r_state == S_SCAN))
        else $error("word stream active outside a scan");

    a_write_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN && r_op == OP_SET_RUN && r_pend))
        else $error("store written outside set_run");

    a_refine_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFINE) |-> (r_rem != '0 && r_rem <= CNT_W'(WORD_W)))
        else $error("select remainder out of range for one word");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or changed");
`endif

endmodule

### hw/rtl/brs_ram.sv
// generic simple dual-port ram with registered read
module brs_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/brs_word_eval.sv
// per-word evaluation: range mask, popcount, lowest and highest set bit
module brs_word_eval (
    input  logic [brs_pkg::WORD_W-1:0] i_data,
    input  logic                       i_word_valid,
    input  logic                       i_lo_here,
    input  logic [brs_pkg::BIT_W-1:0]  i_lo_bit,
    input  logic                       i_hi_here,
    input  logic [brs_pkg::BIT_W-1:0]  i_hi_bit,
    output logic [brs_pkg::WORD_W-1:0] o_sel,
    output logic [brs_pkg::WORD_W-1:0] o_merged,
    output brs_pkg::t_word_info        o_info
);
    import brs_pkg::*;

    logic [WORD_W-1:0] eff;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] mask;
    logic [CNT_W-1:0]  ones;
    logic [BIT_W-1:0]  first_idx;
    logic [BIT_W-1:0]  last_idx;

    // a word never written reads as all zeros
    assign eff     = i_word_valid ? i_data : '0;
    assign lo_mask = i_lo_here ? ({WORD_W{1'b1}} << i_lo_bit) : {WORD_W{1'b1}};
    assign hi_mask = i_hi_here ? ({WORD_W{1'b1}} >> (~i_hi_bit)) : {WORD_W{1'b1}};
    assign mask    = lo_mask & hi_mask;

    assign o_sel    = eff & mask;
    assign o_merged = eff | mask;

    always_comb begin
        ones      = '0;
        first_idx = '0;
        last_idx  = '0;
        for (int k = 0; k < WORD_W; k++) begin
            ones = ones + CNT_W'(o_sel[k]);
        end
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (o_sel[k]) begin
                first_idx = BIT_W'(k);
            end
        end
        for (int k = 0; k < WORD_W; k++) begin
            if (o_sel[k]) begin
                last_idx = BIT_W'(k);
            end
        end
    end

    assign o_info.ones      = ones;
    assign o_info.any       = |o_sel;
    assign o_info.first_idx = first_idx;
    assign o_info.last_idx  = last_idx;

endmodule
